@@ rtl/ccsp_pkg.sv @@
package ccsp_pkg;

  localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;
  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_P       = 8'h50;
  localparam logic [7:0] CHAR_I       = 8'h49;
  localparam logic [7:0] CHAR_C       = 8'h43;
  localparam logic [7:0] CHAR_O       = 8'h4F;
  localparam logic [7:0] CHAR_N       = 8'h4E;

  localparam logic [3:0] FIELD_TAG  = 4'd0;
  localparam logic [3:0] FIELD_HEAT = 4'd2;
  localparam logic [3:0] FIELD_FAN  = 4'd4;
  localparam logic [3:0] FIELD_MAX  = 4'd15;

  localparam logic [2:0] POS_MISMATCH = 3'd7;

  typedef logic [7:0] byte_t;

  // Length of the text a field must match; zero for fields that are not checked.
  function automatic logic [1:0] target_len(input logic [3:0] field);
    logic [1:0] len;
    len = 2'd0;
    if (field == FIELD_TAG) begin
      len = 2'd3;
    end else if (field == FIELD_HEAT || field == FIELD_FAN) begin
      len = 2'd2;
    end
    return len;
  endfunction

  // Expected character at a position of a checked field.
  function automatic byte_t target_char(input logic [3:0] field, input logic [1:0] pos);
    byte_t ch;
    if (field == FIELD_TAG) begin
      case (pos)
        2'd0:    ch = CHAR_P;
        2'd1:    ch = CHAR_I;
        2'd2:    ch = CHAR_C;
        default: ch = CHAR_P;
      endcase
    end else begin
      ch = pos[0] ? CHAR_N : CHAR_O;
    end
    return ch;
  endfunction

endpackage

@@ rtl/ccsp_byte_if.sv @@
interface ccsp_byte_if;
  import ccsp_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/ccsp_result_if.sv @@
interface ccsp_result_if;
  logic valid;
  logic ready;
  logic heat_on;
  logic fan_on;
  logic sentence_end;
  logic checksum_ok;
  logic command_applied;

  modport source (output valid, output heat_on, output fan_on, output sentence_end,
                  output checksum_ok, output command_applied, input ready);
  modport sink   (input valid, input heat_on, input fan_on, input sentence_end,
                  input checksum_ok, input command_applied, output ready);
endinterface

@@ rtl/checked_command_sentence_parser_top.sv @@
// Command sentence parser with XOR checksum. Each received byte is one input
// item and yields exactly one result item carrying the current heat and fan
// levels. A '$' opens a sentence (and discards any open one); a newline closes
// it and raises sentence_end. Bytes outside a sentence are ignored. The first
// SENTENCE_BUFFER_BYTES-1 bytes of a sentence ('$' included) are parsed, later
// ones are dropped but a newline still closes the sentence. The checksum is the
// XOR of the bytes between '$' and the first '*', compared with the decimal
// number (modulo 256) after the last '*'. When it matches and field 0 reads
// "PIC", heat follows whether field 2 reads "ON" and fan whether field 4 reads
// "ON"; a sentence without '*' is rejected. Each byte passes the input register,
// then is parsed into the result register, and one byte is taken every
// cycle; the only stall comes from the result side holding ready low. All
// parse state sits in flip-flops; no memory is used.
module checked_command_sentence_parser_top
  import ccsp_pkg::*;
#(
  parameter int SENTENCE_BUFFER_BYTES = 64
) (
  input  logic          clk,
  input  logic          rst,
  ccsp_byte_if.sink     rx,
  ccsp_result_if.source res
);

  localparam int KCW        = $clog2(SENTENCE_BUFFER_BYTES);
  localparam int KEEP_LIMIT = SENTENCE_BUFFER_BYTES - 1;

  // Input register
  logic  byte_valid;
  byte_t byte_q;

  // Parse state
  logic           in_sentence,      in_sentence_next;
  logic [KCW-1:0] kept_count,       kept_count_next;
  logic [3:0]     field_number,     field_number_next;
  logic [2:0]     field_char_pos,   field_char_pos_next;
  logic           tag_match,        tag_match_next;
  logic           heat_field_match, heat_field_match_next;
  logic           fan_field_match,  fan_field_match_next;
  logic           pend_tag,         pend_tag_next;
  logic           pend_heat,        pend_heat_next;
  logic           pend_fan,         pend_fan_next;
  logic           first_star_seen,  first_star_seen_next;
  logic           digits_open,      digits_open_next;
  byte_t          received_sum,     received_sum_next;
  byte_t          running_xor,      running_xor_next;
  logic           heat_level,       heat_level_next;
  logic           fan_level,        fan_level_next;

  logic advance;
  logic fire;
  logic ended_c;
  logic ck_ok_c;
  logic applied_c;

  // The result register moves when it is empty or being taken.
  assign advance  = !res.valid || res.ready;
  assign fire     = byte_valid && advance;
  assign rx.ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (rx.ready) begin
      byte_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      byte_q <= rx.rx_byte;
    end
  end

  always_comb begin
    logic [1:0] len;
    logic       star;
    logic       delim;
    logic       hit;

    in_sentence_next      = in_sentence;
    kept_count_next       = kept_count;
    field_number_next     = field_number;
    field_char_pos_next   = field_char_pos;
    tag_match_next        = tag_match;
    heat_field_match_next = heat_field_match;
    fan_field_match_next  = fan_field_match;
    pend_tag_next         = pend_tag;
    pend_heat_next        = pend_heat;
    pend_fan_next         = pend_fan;
    first_star_seen_next  = first_star_seen;
    digits_open_next      = digits_open;
    received_sum_next     = received_sum;
    running_xor_next      = running_xor;
    heat_level_next       = heat_level;
    fan_level_next        = fan_level;
    ended_c               = 1'b0;
    ck_ok_c               = 1'b0;
    applied_c             = 1'b0;

    star  = (byte_q == CHAR_STAR);
    delim = star || (byte_q == CHAR_COMMA);
    len   = target_len(field_number);
    hit   = (len != 2'd0) && (field_char_pos == {1'b0, len});

    if (fire) begin
      if (byte_q == CHAR_DOLLAR) begin
        in_sentence_next      = 1'b1;
        kept_count_next       = KCW'(1);
        field_number_next     = FIELD_TAG;
        field_char_pos_next   = 3'd0;
        tag_match_next        = 1'b0;
        heat_field_match_next = 1'b0;
        fan_field_match_next  = 1'b0;
        pend_tag_next         = 1'b0;
        pend_heat_next        = 1'b0;
        pend_fan_next         = 1'b0;
        first_star_seen_next  = 1'b0;
        digits_open_next      = 1'b0;
        received_sum_next     = '0;
        running_xor_next      = '0;
      end else if (in_sentence) begin
        if (kept_count < KCW'(KEEP_LIMIT)) begin
          kept_count_next = kept_count + KCW'(1);

          if (!first_star_seen && !star) begin
            running_xor_next = running_xor ^ byte_q;
          end

          // Digit run after a star accumulates modulo 256
          if (star) begin
            digits_open_next  = 1'b1;
            received_sum_next = '0;
          end else if (digits_open && byte_q >= CHAR_ZERO && byte_q <= CHAR_NINE) begin
            received_sum_next = (received_sum << 3) + (received_sum << 1)
                              + (byte_q - CHAR_ZERO);
          end else begin
            digits_open_next = 1'b0;
          end

          if (delim) begin
            if (field_number == FIELD_TAG) begin
              pend_tag_next = hit;
            end else if (field_number == FIELD_HEAT) begin
              pend_heat_next = hit;
            end else if (field_number == FIELD_FAN) begin
              pend_fan_next = hit;
            end
            if (field_number != FIELD_MAX) begin
              field_number_next = field_number + 4'd1;
            end
            field_char_pos_next = 3'd0;
            if (star) begin
              first_star_seen_next  = 1'b1;
              tag_match_next        = (field_number == FIELD_TAG)  ? hit : pend_tag;
              heat_field_match_next = (field_number == FIELD_HEAT) ? hit : pend_heat;
              fan_field_match_next  = (field_number == FIELD_FAN)  ? hit : pend_fan;
            end
          end else if (len != 2'd0) begin
            if (field_char_pos < {1'b0, len}
                && byte_q == target_char(field_number, field_char_pos[1:0])) begin
              field_char_pos_next = field_char_pos + 3'd1;
            end else begin
              field_char_pos_next = POS_MISMATCH;
            end
          end
        end

        // A kept newline changes neither the star flag, the field results
        // nor the received sum, so the check reads the current state.
        if (byte_q == CHAR_NEWLINE) begin
          ended_c          = 1'b1;
          ck_ok_c          = first_star_seen && (running_xor == received_sum);
          applied_c        = ck_ok_c && tag_match;
          in_sentence_next = 1'b0;
          if (applied_c) begin
            heat_level_next = heat_field_match;
            fan_level_next  = fan_field_match;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence      <= 1'b0;
      kept_count       <= '0;
      field_number     <= '0;
      field_char_pos   <= '0;
      tag_match        <= 1'b0;
      heat_field_match <= 1'b0;
      fan_field_match  <= 1'b0;
      pend_tag         <= 1'b0;
      pend_heat        <= 1'b0;
      pend_fan         <= 1'b0;
      first_star_seen  <= 1'b0;
      digits_open      <= 1'b0;
      received_sum     <= '0;
      running_xor      <= '0;
      heat_level       <= 1'b0;
      fan_level        <= 1'b0;
    end else begin
      in_sentence      <= in_sentence_next;
      kept_count       <= kept_count_next;
      field_number     <= field_number_next;
      field_char_pos   <= field_char_pos_next;
      tag_match        <= tag_match_next;
      heat_field_match <= heat_field_match_next;
      fan_field_match  <= fan_field_match_next;
      pend_tag         <= pend_tag_next;
      pend_heat        <= pend_heat_next;
      pend_fan         <= pend_fan_next;
      first_star_seen  <= first_star_seen_next;
      digits_open      <= digits_open_next;
      received_sum     <= received_sum_next;
      running_xor      <= running_xor_next;
      heat_level       <= heat_level_next;
      fan_level        <= fan_level_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res.heat_on         <= heat_level_next;
      res.fan_on          <= fan_level_next;
      res.sentence_end    <= ended_c;
      res.checksum_ok     <= ck_ok_c;
      res.command_applied <= applied_c;
    end
  end

  // Assertions
  a_applied_needs_ok: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.command_applied |-> res.checksum_ok)
    else $error("command applied without a good checksum");

  a_ok_needs_end: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.checksum_ok |-> res.sentence_end)
    else $error("checksum flagged on a byte that ended no sentence");

  a_levels_only_on_apply: assert property (@(posedge clk) disable iff (rst)
    !$stable(heat_level) || !$stable(fan_level) |-> $past(rst) || $past(applied_c))
    else $error("output level changed without an applied command");

  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    kept_count <= KCW'(KEEP_LIMIT))
    else $error("kept byte count ran past the buffer limit");

  a_char_pos_legal: assert property (@(posedge clk) disable iff (rst)
    field_char_pos <= 3'd3 || field_char_pos == POS_MISMATCH)
    else $error("field match position holds an illegal code");

endmodule
